>>> src/pnsa_pkg.sv
// shared types and constants of the pot/network speed arbiter
// no dependencies
package pnsa_pkg;

   localparam int unsigned SAMPLES_PER_WINDOW = 10;

   localparam int unsigned ADC_W    = 12;
   localparam int unsigned POT_W    = 10;
   localparam int unsigned SPEED_W  = 12;
   localparam int unsigned ID_W     = 11;
   localparam int unsigned CMD_W    = 8;
   localparam int unsigned SUM_W    = 16;
   localparam int unsigned CNT_W    = 5;
   localparam int unsigned EVENT_W  = 2;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 11;

   // divider: 22-bit dividend, 12-bit divisor, one quotient bit a cycle
   localparam int unsigned DIVD_W   = 22;
   localparam int unsigned DIVS_W   = 12;
   localparam int unsigned STEP_W   = 5;

   localparam logic [ADC_W-1:0]   SCALE_DEN    = 12'd4095;
   localparam logic [POT_W-1:0]   SCALE_NUM    = 10'd1000;
   localparam logic [SPEED_W-1:0] COMMAND_STEP = 12'd10;

   localparam logic [POT_W-1:0]   THRESHOLD_RESET  = 10'd25;
   localparam logic [ID_W-1:0]    COMMAND_ID_RESET = 11'd256;

   localparam logic [CSR_IDX_W-1:0] CSR_CHANGE_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND_ID       = 1'b1;

   localparam logic ACTION_FRAME  = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   typedef enum logic [EVENT_W-1:0] {
      EV_HELD     = 2'd0,
      EV_PRIMED   = 2'd1,
      EV_TAKEOVER = 2'd2,
      EV_ZEROED   = 2'd3
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG_START,
      ST_AVG_WAIT,
      ST_SCALE_MUL,
      ST_SCALE_FOLD,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

>>> src/pnsa_req_if.sv
// request channel of the speed arbiter
// depends on pnsa_pkg
interface pnsa_req_if;
   logic                           valid;
   logic                           ready;
   logic                           action;
   logic [pnsa_pkg::ID_W-1:0]      frame_id;
   logic [pnsa_pkg::CMD_W-1:0]     command_byte;
   logic [pnsa_pkg::ADC_W-1:0]     adc_value;
   logic                           adc_ok;

   modport source (output valid, action, frame_id, command_byte, adc_value, adc_ok,
                   input ready);
   modport sink (input valid, action, frame_id, command_byte, adc_value, adc_ok,
                 output ready);
endinterface

>>> src/pnsa_rsp_if.sv
// response channel of the speed arbiter
// depends on pnsa_pkg
interface pnsa_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pnsa_pkg::SPEED_W-1:0]     speed;
   logic [pnsa_pkg::POT_W-1:0]       pot_value;
   logic [pnsa_pkg::EVENT_W-1:0]     event_res;

   modport source (output valid, speed, pot_value, event_res, input ready);
   modport sink (input valid, speed, pot_value, event_res, output ready);
endinterface

>>> src/pnsa_div.sv
// restoring divider, one quotient bit per cycle
// depends on pnsa_pkg
module pnsa_div (
   input  logic                          clock,
   input  logic                          reset,
   input  pnsa_pkg::div_ctl_type         ctl,
   input  logic [pnsa_pkg::DIVD_W-1:0]   dividend,
   input  logic [pnsa_pkg::DIVS_W-1:0]   divisor,
   output pnsa_pkg::div_sts_type         sts,
   output logic [pnsa_pkg::DIVD_W-1:0]   quotient
);

   logic [pnsa_pkg::DIVD_W-1:0] quo_ff, quo_in;
   logic [pnsa_pkg::DIVS_W-1:0] rem_ff, rem_in;
   logic [pnsa_pkg::DIVS_W-1:0] dvs_ff, dvs_in;
   logic [pnsa_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [pnsa_pkg::DIVS_W:0]   trial;
   logic                        fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[pnsa_pkg::DIVD_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = pnsa_pkg::STEP_W'(pnsa_pkg::DIVD_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[pnsa_pkg::DIVD_W-2:0], fits};
         rem_in = fits ? pnsa_pkg::DIVS_W'(trial - {1'b0, dvs_ff})
                       : trial[pnsa_pkg::DIVS_W-1:0];
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

>>> src/pot_network_speed_arbiter_top.sv
// top level of the pot/network speed arbiter: sequencer, state and output register
// depends on pnsa_pkg, pnsa_req_if, pnsa_rsp_if and pnsa_div
//
// usage
//   req_ch carries one request per handshake (valid and ready high at a clock edge):
//   either a received frame (action 0) or one adc sample (action 1)
//   a frame whose id equals command_id sets the speed to command_byte * 10, no response
//   samples build a window of ten; the tenth sample of a window triggers one response
//   on rsp_ch with speed, the scaled pot reading (0..1000) and the event code
//   csr_we/csr_index/csr_wdata write change_threshold (index 0) or command_id (index 1)
// sequencing
//   frames and non-final samples leave the arbiter idle, so ready stays high
//   the final sample of a window holds req_ch.ready low through the divider start,
//   22 divider steps and the divider done for sum / valid count, a multiply by 1000,
//   a shift-add fold that divides by 4095 and a decide; the response is valid next cycle
// reset
//   synchronous, active high: speed, history, window and priming cleared, thresholds
//   back to 25 and id 256, no response pending
// stalls
//   a finished response sits in the output register while new requests are taken;
//   a next window that completes meanwhile waits in the decide step until it frees
module pot_network_speed_arbiter_top (
   input  logic                              clock,
   input  logic                              reset,
   pnsa_req_if.sink                          req_ch,
   pnsa_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [pnsa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pnsa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // configuration
   logic [pnsa_pkg::POT_W-1:0]   threshold_ff;
   logic [pnsa_pkg::ID_W-1:0]    command_id_ff;

   // arbiter state
   pnsa_pkg::state_type          state_ff, state_in;
   logic [pnsa_pkg::SPEED_W-1:0] speed_ff, speed_in;
   logic [pnsa_pkg::POT_W-1:0]   prev_pot_ff, prev_pot_in;
   logic                         primed_ff, primed_in;
   logic [pnsa_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [pnsa_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [pnsa_pkg::CNT_W-1:0]   index_ff, index_in;
   logic [pnsa_pkg::DIVD_W-1:0]  prod_ff, prod_in;
   logic [pnsa_pkg::POT_W-1:0]   pot_ff, pot_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [pnsa_pkg::SPEED_W-1:0] rsp_speed_ff, rsp_speed_in;
   logic [pnsa_pkg::POT_W-1:0]   rsp_pot_ff, rsp_pot_in;
   pnsa_pkg::event_type          rsp_event_ff, rsp_event_in;

   // divider hookup
   pnsa_pkg::div_ctl_type        div_ctl;
   pnsa_pkg::div_sts_type        div_sts;
   logic [pnsa_pkg::DIVD_W-1:0]  div_dividend;
   logic [pnsa_pkg::DIVS_W-1:0]  div_divisor;
   logic [pnsa_pkg::DIVD_W-1:0]  div_quotient;

   logic                         req_fire;
   logic [pnsa_pkg::SUM_W-1:0]   sum_next;
   logic [pnsa_pkg::CNT_W-1:0]   count_next;
   logic [pnsa_pkg::CNT_W-1:0]   index_next;
   logic [pnsa_pkg::ADC_W-1:0]   avg;
   logic [pnsa_pkg::DIVD_W-1:0]  pot_fold;
   logic [pnsa_pkg::POT_W-1:0]   diff;
   logic                         out_free;

   pnsa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .sts      (div_sts),
      .quotient (div_quotient)
   );

   assign req_ch.ready = (state_ff == pnsa_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // window accumulation for the incoming sample
   assign sum_next   = sum_ff + (req_ch.adc_ok ? pnsa_pkg::SUM_W'(req_ch.adc_value) : '0);
   assign count_next = count_ff + pnsa_pkg::CNT_W'(req_ch.adc_ok);
   assign index_next = index_ff + 1'b1;

   // average with clamp; no valid sample reads as zero
   always_comb begin
      if (count_ff == '0) begin
         avg = '0;
      end else if (div_quotient > pnsa_pkg::DIVD_W'(pnsa_pkg::SCALE_DEN)) begin
         avg = pnsa_pkg::SCALE_DEN;
      end else begin
         avg = div_quotient[pnsa_pkg::ADC_W-1:0];
      end
   end

   // x / 4095 as (x + (x >> 12) + 1) >> 12, exact for every product of avg and 1000
   assign pot_fold = prod_ff + (prod_ff >> pnsa_pkg::ADC_W) + pnsa_pkg::DIVD_W'(1);

   assign diff = (pot_ff >= prev_pot_ff) ? pot_ff - prev_pot_ff : prev_pot_ff - pot_ff;

   always_comb begin
      state_in      = state_ff;
      speed_in      = speed_ff;
      prev_pot_in   = prev_pot_ff;
      primed_in     = primed_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      index_in      = index_ff;
      prod_in       = prod_ff;
      pot_in        = pot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_speed_in  = rsp_speed_ff;
      rsp_pot_in    = rsp_pot_ff;
      rsp_event_in  = rsp_event_ff;
      div_ctl.start = 1'b0;
      div_dividend  = pnsa_pkg::DIVD_W'(sum_ff);
      div_divisor   = pnsa_pkg::DIVS_W'(count_ff);

      case (state_ff)
         pnsa_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.action == pnsa_pkg::ACTION_FRAME) begin
                  if (req_ch.frame_id == command_id_ff) begin
                     speed_in = pnsa_pkg::SPEED_W'(req_ch.command_byte) *
                                pnsa_pkg::COMMAND_STEP;
                  end
               end else begin
                  sum_in   = sum_next;
                  count_in = count_next;
                  index_in = index_next;
                  if (index_next == pnsa_pkg::CNT_W'(pnsa_pkg::SAMPLES_PER_WINDOW)) begin
                     state_in = pnsa_pkg::ST_AVG_START;
                  end
               end
            end
         end
         pnsa_pkg::ST_AVG_START: begin
            // sum / valid count
            div_ctl.start = 1'b1;
            state_in      = pnsa_pkg::ST_AVG_WAIT;
         end
         pnsa_pkg::ST_AVG_WAIT: begin
            if (div_sts.done) begin
               state_in = pnsa_pkg::ST_SCALE_MUL;
            end
         end
         pnsa_pkg::ST_SCALE_MUL: begin
            prod_in  = pnsa_pkg::DIVD_W'(avg) * pnsa_pkg::DIVD_W'(pnsa_pkg::SCALE_NUM);
            state_in = pnsa_pkg::ST_SCALE_FOLD;
         end
         pnsa_pkg::ST_SCALE_FOLD: begin
            // avg * 1000 / 4095
            pot_in   = pot_fold[pnsa_pkg::ADC_W +: pnsa_pkg::POT_W];
            state_in = pnsa_pkg::ST_DECIDE;
         end
         pnsa_pkg::ST_DECIDE: begin
            if (out_free) begin
               rsp_event_in = pnsa_pkg::EV_HELD;
               if (!primed_ff) begin
                  speed_in     = pnsa_pkg::SPEED_W'(pot_ff);
                  rsp_event_in = pnsa_pkg::EV_PRIMED;
               end else if (diff >= threshold_ff) begin
                  speed_in     = pnsa_pkg::SPEED_W'(pot_ff);
                  rsp_event_in = pnsa_pkg::EV_TAKEOVER;
               end else if (pot_ff == '0 && speed_ff != '0) begin
                  speed_in     = '0;
                  rsp_event_in = pnsa_pkg::EV_ZEROED;
               end
               primed_in    = 1'b1;
               prev_pot_in  = pot_ff;
               sum_in       = '0;
               count_in     = '0;
               index_in     = '0;
               rsp_valid_in = 1'b1;
               rsp_speed_in = speed_in;
               rsp_pot_in   = pot_ff;
               state_in     = pnsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pnsa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      pot_ff       <= pot_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_pot_ff   <= rsp_pot_in;
      rsp_event_ff <= rsp_event_in;
      if (reset) begin
         state_ff      <= pnsa_pkg::ST_IDLE;
         speed_ff      <= '0;
         prev_pot_ff   <= '0;
         primed_ff     <= 1'b0;
         sum_ff        <= '0;
         count_ff      <= '0;
         index_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         threshold_ff  <= pnsa_pkg::THRESHOLD_RESET;
         command_id_ff <= pnsa_pkg::COMMAND_ID_RESET;
      end else begin
         state_ff     <= state_in;
         speed_ff     <= speed_in;
         prev_pot_ff  <= prev_pot_in;
         primed_ff    <= primed_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
         // register writes are to arrive only while idle; the block itself does not enforce it
         if (csr_we) begin
            case (csr_index)
               pnsa_pkg::CSR_CHANGE_THRESHOLD: threshold_ff <= csr_wdata[pnsa_pkg::POT_W-1:0];
               pnsa_pkg::CSR_COMMAND_ID:       command_id_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.speed     = rsp_speed_ff;
   assign rsp_ch.pot_value = rsp_pot_ff;
   assign rsp_ch.event_res = rsp_event_ff;

endmodule
